// ----- sv/mtkx_pkg.sv -----
// ----------------------------------------------------------------------------
// mtkx_pkg
// Shared types, constants and helper functions for the MT19937 keystream
// decryptor: table geometry, twist and temper constants, register indexes.
// ----------------------------------------------------------------------------
package mtkx_pkg;

  localparam int unsigned TableWords = 624;
  localparam int unsigned TwistShift = 397;
  localparam int unsigned PosW       = 10;
  localparam int unsigned WordW      = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [WordW-1:0] TwistMatrix = 32'h9908_B0DF;
  localparam logic [WordW-1:0] UpperMask   = 32'h8000_0000;
  localparam logic [WordW-1:0] LowerMask   = 32'h7FFF_FFFF;
  localparam logic [WordW-1:0] TemperB     = 32'h9D2C_5680;
  localparam logic [WordW-1:0] TemperC     = 32'hEFC6_0000;
  localparam logic [WordW-1:0] ResetSeed   = 32'h0005_D3E3;
  localparam logic [WordW-1:0] ResetMult   = 32'h0001_0DCD;

  localparam logic [PosW-1:0] LastPos   = PosW'(TableWords - 1);
  localparam logic [PosW-1:0] FarWrap   = PosW'(TableWords - TwistShift);
  localparam logic [PosW-1:0] FarOffset = PosW'(TwistShift);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSeedValue = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSeedMult  = CfgIdxW'(1);

  typedef logic [WordW-1:0] word_t;
  typedef logic [PosW-1:0]  pos_t;

  function automatic pos_t pos_inc(input pos_t p);
    pos_t r;
    r = (p == LastPos) ? '0 : p + PosW'(1);
    return r;
  endfunction

  function automatic pos_t far_pos(input pos_t p);
    pos_t r;
    r = (p < FarWrap) ? p + FarOffset : p - FarWrap;
    return r;
  endfunction

  // One step of the standard twist recurrence
  function automatic word_t twist_mix(input word_t cur, input word_t nxt, input word_t far);
    word_t y;
    word_t v;
    y = (cur & UpperMask) | (nxt & LowerMask);
    v = y >> 1;
    if (y[0]) begin
      v = v ^ TwistMatrix;
    end
    return far ^ v;
  endfunction

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ----- sv/mtkx_if.sv -----
// ----------------------------------------------------------------------------
// mtkx channel interfaces
// Valid/ready channels for cipher bytes in, plain bytes out and register
// writes.
// ----------------------------------------------------------------------------
interface mtkx_in_if
  import mtkx_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] cipher_byte;
  logic             final_byte;

  modport source (output valid, output cipher_byte, output final_byte, input ready);
  modport sink   (input valid, input cipher_byte, input final_byte, output ready);
endinterface

interface mtkx_out_if
  import mtkx_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] plain_byte;
  logic             final_out;

  modport source (output valid, output plain_byte, output final_out, input ready);
  modport sink   (input valid, input plain_byte, input final_out, output ready);
endinterface

interface mtkx_cfg_if
  import mtkx_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/mt19937_keystream_xor_decrypt.sv -----
// ----------------------------------------------------------------------------
// mt19937_keystream_xor_decrypt
// Byte decryptor: XOR with the low byte of tempered MT19937 words, with
// the twist done lazily one word per byte in a single 624x32 table memory.
// ----------------------------------------------------------------------------
// For each byte the next table word is read when the byte is accepted and the
// word 397 places on in ST_RD_FAR, one after the other on the single read port;
// the combine and write-back in ST_CALC overlaps the acceptance of the following
// byte, and both wait while the output is stalled. After reset and after a byte
// marked final the table is reseeded by a sweep through ST_SEED_INIT and ST_SEED,
// one word per cycle through the seed multiplier, while no byte is accepted. A
// register write to any index during a reseed, or after it and before the first
// byte of the stream, restarts the sweep. The register port always accepts its beats.
module mt19937_keystream_xor_decrypt
  import mtkx_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  mtkx_in_if.sink    cipher_i,
  mtkx_out_if.source plain_o,
  mtkx_cfg_if.sink   cfg_i
);

  typedef enum logic [2:0] {
    ST_SEED_INIT,
    ST_SEED,
    ST_IDLE,
    ST_RD_FAR,
    ST_CALC
  } state_e;

  state_e state_q, state_d;
  pos_t   pos_q, pos_d;
  pos_t   seed_ctr_q, seed_ctr_d;
  word_t  word_q, word_d;
  word_t  cur_q, cur_d;
  word_t  nxt_q, nxt_d;
  word_t  seed_value_q, seed_value_d;
  word_t  seed_mult_q, seed_mult_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic [ByteW-1:0] plain_q, plain_d;
  logic   fin_q, fin_d;
  logic   fin_out_q, fin_out_d;
  logic   fresh_q, fresh_d;
  logic   out_valid_q, out_valid_d;

  // table memory
  word_t  mem [TableWords];
  word_t  rdata_q;
  pos_t   raddr;
  pos_t   waddr;
  word_t  wdata;
  logic   we;

  logic   out_free;
  logic   in_take;
  logic   cfg_take;
  word_t  new_word;
  word_t  key_word;

  assign out_free  = !out_valid_q || plain_o.ready;
  assign in_take   = cipher_i.valid && cipher_i.ready;
  assign cfg_take  = cfg_i.valid;
  assign new_word  = twist_mix(cur_q, nxt_q, rdata_q);
  assign key_word  = temper(new_word);

  assign cipher_i.ready = ((state_q == ST_IDLE) && !(fresh_q && cfg_i.valid)) ||
                          ((state_q == ST_CALC) && !fin_q && out_free);
  assign cfg_i.ready      = 1'b1;
  assign plain_o.valid      = out_valid_q;
  assign plain_o.plain_byte = plain_q;
  assign plain_o.final_out  = fin_out_q;

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    seed_ctr_d   = seed_ctr_q;
    word_d       = word_q;
    cur_d        = cur_q;
    nxt_d        = nxt_q;
    seed_value_d = seed_value_q;
    seed_mult_d  = seed_mult_q;
    byte_d       = byte_q;
    plain_d      = plain_q;
    fin_d        = fin_q;
    fin_out_d    = fin_out_q;
    fresh_d      = fresh_q;
    out_valid_d  = out_valid_q && !plain_o.ready;
    raddr        = pos_inc(pos_q);
    waddr        = pos_q;
    wdata        = new_word;
    we           = 1'b0;

    if (cfg_take) begin
      case (cfg_i.index)
        CfgSeedValue: seed_value_d = cfg_i.data;
        CfgSeedMult:  seed_mult_d  = cfg_i.data;
        default: ;
      endcase
    end

    case (state_q)
      ST_SEED_INIT: begin
        word_d     = seed_value_q;
        cur_d      = seed_value_q;
        seed_ctr_d = '0;
        state_d    = ST_SEED;
      end
      ST_SEED: begin
        we         = 1'b1;
        waddr      = seed_ctr_q;
        wdata      = word_q;
        word_d     = word_q * seed_mult_q;
        seed_ctr_d = pos_inc(seed_ctr_q);
        if (seed_ctr_q == LastPos) begin
          state_d = ST_IDLE;
          pos_d   = '0;
          fresh_d = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          byte_d  = cipher_i.cipher_byte;
          fin_d   = cipher_i.final_byte;
          fresh_d = 1'b0;
          state_d = ST_RD_FAR;
        end
      end
      ST_RD_FAR: begin
        nxt_d   = rdata_q;
        raddr   = far_pos(pos_q);
        state_d = ST_CALC;
      end
      ST_CALC: begin
        // keep the far word in the read register while the result is blocked
        raddr = far_pos(pos_q);
        if (out_free) begin
          // next beat's first read is two words on from the one written here
          raddr       = pos_inc(pos_inc(pos_q));
          we          = 1'b1;
          out_valid_d = 1'b1;
          plain_d     = byte_q ^ key_word[ByteW-1:0];
          fin_out_d   = fin_q;
          cur_d       = nxt_q;
          pos_d       = pos_inc(pos_q);
          if (fin_q) begin
            state_d = ST_SEED_INIT;
          end else if (in_take) begin
            byte_d  = cipher_i.cipher_byte;
            fin_d   = cipher_i.final_byte;
            state_d = ST_RD_FAR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_SEED_INIT;
    endcase

    // register written, to any index, before the stream used the table: seed again
    if (cfg_take && ((state_q == ST_SEED_INIT) || (state_q == ST_SEED) ||
                     ((state_q == ST_IDLE) && fresh_q))) begin
      state_d = ST_SEED_INIT;
      fresh_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SEED_INIT;
      pos_q        <= '0;
      seed_ctr_q   <= '0;
      fin_q        <= 1'b0;
      fresh_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      seed_value_q <= ResetSeed;
      seed_mult_q  <= ResetMult;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      seed_ctr_q   <= seed_ctr_d;
      fin_q        <= fin_d;
      fresh_q      <= fresh_d;
      out_valid_q  <= out_valid_d;
      seed_value_q <= seed_value_d;
      seed_mult_q  <= seed_mult_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q    <= word_d;
    cur_q     <= cur_d;
    nxt_q     <= nxt_d;
    byte_q    <= byte_d;
    plain_q   <= plain_d;
    fin_out_q <= fin_out_d;
  end

endmodule

// ----- sv/mtkx_checker.sv -----
// ----------------------------------------------------------------------------
// mtkx_checker
// Port-level checks for the keystream decryptor, bound to the top level.
// ----------------------------------------------------------------------------
module mtkx_checker
  import mtkx_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ByteW-1:0] out_byte_i,
  input logic             out_final_i,
  input logic             cfg_ready_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign pend_d  = pend_q + 2'(in_acc) - 2'(out_acc);

  // beats taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
                                    $stable(out_final_i))
    else $error("result beat dropped or changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 2'd0)
    else $error("result beat without an input beat");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many beats in flight");

  a_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_acc)
    else $error("input beats accepted on consecutive cycles");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("register port stalled");

endmodule

bind mt19937_keystream_xor_decrypt mtkx_checker u_mtkx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cipher_i.valid),
  .in_ready_i  (cipher_i.ready),
  .out_valid_i (plain_o.valid),
  .out_ready_i (plain_o.ready),
  .out_byte_i  (plain_o.plain_byte),
  .out_final_i (plain_o.final_out),
  .cfg_ready_i (cfg_i.ready)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MT19937 keystream byte decryptor. A local
// twister model predicts each plain byte as its cipher byte is accepted, and
// a monitor compares every output beat with the oldest prediction. Covers
// seed register extremes, mid-stream and out-of-range register writes, table
// exhaustion in long streams and random streams under random back-pressure.
// ----------------------------------------------------------------------------
module testbench
  import mtkx_pkg::*;
();

  localparam int unsigned     ItemTarget  = 2000;
  localparam int unsigned     LongStream  = 1260;
  localparam int unsigned     SettlePause = 700;
  localparam int unsigned     TailCycles  = 64;
  localparam longint unsigned CycleLimit  = 8_000_000;
  localparam logic [CfgIdxW-1:0] CfgIdxTop = '1;

  typedef struct packed {
    logic [ByteW-1:0] plain;
    logic             fin;
  } plain_beat_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] idx;
    word_t              val;
  } reg_write_t;

  logic clk_i;
  logic rst_ni;

  mtkx_in_if  cipher_if ();
  mtkx_out_if plain_if ();
  mtkx_cfg_if cfg_if ();

  mt19937_keystream_xor_decrypt u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cipher_i(cipher_if),
    .plain_o (plain_if),
    .cfg_i   (cfg_if)
  );

  // Keystream model state and register shadows
  word_t       key_table [TableWords];
  int unsigned key_pos;
  bit          key_reseed;
  word_t       seed_shadow;
  word_t       mult_shadow;

  plain_beat_t     plain_expected [$];
  reg_write_t      reg_writes [$];
  plain_beat_t     monitor_beat;
  int unsigned     error_count = 0;
  int unsigned     bytes_sent  = 0;
  longint unsigned cycle_count = 0;
  bit              send_idle   = 1'b1;
  bit              recv_idle   = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  function automatic void key_reset();
    key_pos     = 0;
    key_reseed  = 1'b1;
    seed_shadow = ResetSeed;
    mult_shadow = ResetMult;
  endfunction

  function automatic void key_seed();
    word_t       w;
    int unsigned i;
    w = seed_shadow;
    for (i = 0; i < TableWords; i++) begin
      key_table[i] = w;
      w = w * mult_shadow;
    end
  endfunction

  function automatic void key_twist();
    int unsigned i;
    word_t       y;
    word_t       v;
    for (i = 0; i < TableWords; i++) begin
      y = (key_table[i] & UpperMask) | (key_table[(i + 1) % TableWords] & LowerMask);
      v = y >> 1;
      if (y[0]) begin
        v = v ^ TwistMatrix;
      end
      key_table[i] = key_table[(i + TwistShift) % TableWords] ^ v;
    end
  endfunction

  function automatic word_t key_temper(input word_t w);
    word_t t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & TemperB);
    t = t ^ ((t << 15) & TemperC);
    return t ^ (t >> 18);
  endfunction

  function automatic plain_beat_t decrypt_byte(input logic [ByteW-1:0] cb, input logic fin);
    plain_beat_t r;
    word_t       k;
    if (key_reseed) begin
      key_seed();
      key_twist();
      key_pos    = 0;
      key_reseed = 1'b0;
    end else if (key_pos >= TableWords) begin
      key_twist();
      key_pos = 0;
    end
    k = key_temper(key_table[key_pos]);
    key_pos++;
    r.plain = cb ^ k[ByteW-1:0];
    r.fin   = fin;
    if (fin) begin
      key_reseed = 1'b1;
    end
    return r;
  endfunction

  // ------------------------------------------------------------- checking

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : plain_monitor
    if (rst_ni && plain_if.valid && plain_if.ready) begin
      if (plain_expected.size() == 0) begin
        report_error($sformatf("plain beat %02h with nothing expected", plain_if.plain_byte));
      end else begin
        monitor_beat = plain_expected.pop_front();
        if (plain_if.plain_byte !== monitor_beat.plain) begin
          report_error($sformatf("plain_byte expected %02h got %02h",
                                 monitor_beat.plain, plain_if.plain_byte));
        end
        if (plain_if.final_out !== monitor_beat.fin) begin
          report_error($sformatf("final_out expected %0b got %0b",
                                 monitor_beat.fin, plain_if.final_out));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side: random stall before each beat while recv_idle is set
  initial begin : plain_sink
    int unsigned stall;
    plain_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = recv_idle ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        plain_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      plain_if.ready <= 1'b1;
      do @(posedge clk_i); while (!plain_if.valid);
    end
  end

  // ------------------------------------------------------------- drivers

  // Leaves valid high on return so back-to-back beats need no extra edge
  task automatic send_byte(input logic [ByteW-1:0] cb, input logic fin);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      cipher_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cipher_if.valid      <= 1'b1;
    cipher_if.cipher_byte <= cb;
    cipher_if.final_byte  <= fin;
    do @(posedge clk_i); while (!cipher_if.ready);
    plain_expected.push_back(decrypt_byte(cb, fin));
    bytes_sent++;
  endtask

  task automatic wait_drained();
    cipher_if.valid <= 1'b0;
    while (plain_expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic queue_write(input logic [CfgIdxW-1:0] idx, input word_t val);
    reg_write_t w;
    w.idx = idx;
    w.val = val;
    reg_writes.push_back(w);
  endtask

  // Drain, let any reseed sweep finish, then issue the queued register beats
  task automatic reprogram();
    reg_write_t w;
    wait_drained();
    repeat (SettlePause) @(posedge clk_i);
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_if.valid <= 1'b1;
      cfg_if.index <= w.idx;
      cfg_if.data  <= w.val;
      do @(posedge clk_i); while (!cfg_if.ready);
      if (w.idx == CfgSeedValue) begin
        seed_shadow = w.val;
      end else if (w.idx == CfgSeedMult) begin
        mult_shadow = w.val;
      end
    end
    cfg_if.valid <= 1'b0;
  endtask

  function automatic word_t random_word();
    word_t w;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic queue_random_writes();
    queue_write(CfgSeedValue, random_word());
    if ($urandom_range(0, 1) == 0) begin
      queue_write(CfgSeedMult, random_word());
    end
    if ($urandom_range(0, 3) == 0) begin
      queue_write(CfgIdxW'($urandom_range(CfgSeedMult + 1, CfgIdxTop)), $urandom);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_seed();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // Every beat final, so each one reseeds
  task automatic test_single_byte_streams();
    repeat (3) send_byte(ByteW'($urandom), 1'b1);
  endtask

  task automatic test_register_extremes();
    int unsigned k;
    word_t       s;
    word_t       m;
    for (k = 0; k < 4; k++) begin
      case (k)
        0: begin s = '0;            m = 32'h0000_0001; end
        1: begin s = '1;            m = '1;            end
        2: begin s = 32'h8000_0001; m = '0;            end
        default: begin s = 32'h0000_0001; m = '1; end
      endcase
      queue_write(CfgSeedValue, s);
      queue_write(CfgSeedMult, m);
      reprogram();
      send_byte(ByteW'($urandom), 1'b0);
      send_byte(ByteW'($urandom), 1'b1);
    end
  endtask

  // New seed must not apply until the current stream has ended
  task automatic test_midstream_write();
    send_byte(ByteW'($urandom), 1'b0);
    send_byte(ByteW'($urandom), 1'b0);
    queue_write(CfgSeedValue, $urandom);
    queue_write(CfgSeedMult, $urandom);
    reprogram();
    send_byte(ByteW'($urandom), 1'b0);
    send_byte(ByteW'($urandom), 1'b1);
    send_byte(ByteW'($urandom), 1'b1);
  endtask

  task automatic test_ignored_index();
    queue_write(CfgIdxW'(CfgSeedMult + 1), $urandom);
    queue_write(CfgIdxTop, $urandom);
    reprogram();
    send_byte(ByteW'($urandom), 1'b0);
    send_byte(ByteW'($urandom), 1'b1);
  endtask

  // Long enough to exhaust the table twice
  task automatic test_long_stream();
    int unsigned i;
    queue_random_writes();
    reprogram();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    for (i = 0; i < LongStream; i++) begin
      if (i == LongStream / 2) begin
        send_idle = 1'b1;
        recv_idle = 1'b1;
      end
      send_byte(ByteW'($urandom), i == LongStream - 1);
    end
  endtask

  task automatic test_random_streams();
    int unsigned len;
    int unsigned split;
    int unsigned i;
    while (bytes_sent < ItemTarget) begin
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(620, 660) : $urandom_range(1, 40);
      split = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : len;
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      for (i = 0; i < len; i++) begin
        if (i == split) begin
          queue_random_writes();
          reprogram();
        end
        send_byte(ByteW'($urandom), i == len - 1);
      end
      if ($urandom_range(0, 4) == 0) begin
        queue_random_writes();
        reprogram();
      end
    end
  endtask

  initial begin : stimulus
    rst_ni                <= 1'b0;
    cipher_if.valid       <= 1'b0;
    cipher_if.cipher_byte <= '0;
    cipher_if.final_byte  <= 1'b0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= '0;
    cfg_if.data           <= '0;
    key_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_seed();
    test_single_byte_streams();
    test_register_extremes();
    test_midstream_write();
    test_ignored_index();
    test_long_stream();
    test_random_streams();

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/mtkx_pkg.sv
sv/mtkx_if.sv
sv/mt19937_keystream_xor_decrypt.sv
sv/mtkx_checker.sv
verif/testbench.sv
